// ===== rtl/attcs_pkg.sv =====
package attcs_pkg;

  localparam logic [2:0] REQ_ADD      = 3'd0;
  localparam logic [2:0] REQ_REMOVE   = 3'd1;
  localparam logic [2:0] REQ_AFFINITY = 3'd2;
  localparam logic [2:0] REQ_PIN      = 3'd3;
  localparam logic [2:0] REQ_SELECT   = 3'd4;
  localparam logic [2:0] REQ_LOAD     = 3'd5;
  localparam logic [2:0] REQ_BALANCE  = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam int HALF_DIVISOR = 2;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  mask;
    logic        pinned;
    logic [2:0]  home;
  } entry_t;

  // Command broadcast from the controller to every table cell.
  typedef struct packed {
    logic        match_en;
    logic        do_add;
    logic        do_remove;
    logic        do_affinity;
    logic        do_pin;
    logic [31:0] id;
    logic [7:0]  mask;
    logic [2:0]  core;
  } cell_cmd_t;

endpackage

// ===== rtl/attcs_cell.sv =====
module attcs_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  attcs_pkg::cell_cmd_t cmd,
  input  logic                 occ,
  input  logic                 is_tail,
  input  logic                 prev_hit,
  input  attcs_pkg::entry_t    up_entry,
  output attcs_pkg::entry_t    entry,
  output logic                 hit_out,
  output logic                 first_hit
);
  import attcs_pkg::*;

  logic hit;

  assign first_hit = hit && !prev_hit;
  assign hit_out   = hit || prev_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.match_en) begin
      hit <= occ && (entry.id == cmd.id);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_add && is_tail) begin
      entry <= '{id: cmd.id, mask: cmd.mask, pinned: 1'b0, home: 3'd0};
    end else if (cmd.do_remove && hit_out) begin
      entry <= up_entry;
    end else if (cmd.do_affinity && first_hit) begin
      entry.mask <= cmd.mask;
    end else if (cmd.do_pin && first_hit) begin
      entry.pinned <= 1'b1;
      entry.home   <= cmd.core;
    end
  end
endmodule

// ===== rtl/affinity_task_table_core_selector.sv =====
// Task table with affinity-aware core selection. Each request is loaded
// while idle, then all table cells compare their ids in parallel, then the
// change is applied or the core is picked from the hit cell, and then the
// result is presented until taken; the core minimum and the balance spread
// are formed over the per-core load registers in the apply cycle. Removal
// closes the gap in the same cycle, the hit cell and every cell past it
// taking its upper neighbor's entry. Occupancy follows the fill count, so no
// clearing pass is needed after reset. active_cores is written only while idle.
module affinity_task_table_core_selector #(
  parameter int TASK_DEPTH = 64,
  parameter int MAX_CORES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[2:0]
  input  logic [2:0]  s_tuser,
  // task_id[31:0], allow_mask[39:32], core_index[42:40], load_value[58:43],
  // zero fill up to 63
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], chosen_core[4:2], echo_task_id[36:5], table_fill[43:37],
  // imbalance[44], event_total[76:45], zero fill up to 79
  output logic [79:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import attcs_pkg::*;

  localparam int CW = $clog2(TASK_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]  state;
  logic [3:0]  active_cores;
  logic [2:0]  req;
  logic [31:0] id;
  logic [7:0]  mask;
  logic [2:0]  core;
  logic [15:0] load;
  logic [CW-1:0] count;
  logic [15:0] loads [MAX_CORES];
  logic [31:0] events;

  logic [1:0]  r_status;
  logic [2:0]  r_chosen;
  logic [31:0] r_echo;
  logic        r_imb;

  logic [5:0]  ncores;
  always_comb begin
    ncores = {2'b0, active_cores};
    if (ncores == 6'd0) ncores = 6'd1;
    if (ncores > 6'(MAX_CORES)) ncores = 6'(MAX_CORES);
  end

  entry_t    ent  [TASK_DEPTH];
  entry_t    up   [TASK_DEPTH];
  logic      hchn [TASK_DEPTH+1];
  logic      fh   [TASK_DEPTH];
  logic      occ  [TASK_DEPTH];
  cell_cmd_t cmd;

  assign hchn[0] = 1'b0;

  logic full;
  assign full = (count == CW'(TASK_DEPTH));

  logic core_ok;
  assign core_ok = {3'b0, core} < ncores;

  logic any_hit;
  assign any_hit = hchn[TASK_DEPTH];

  always_comb begin
    cmd = '0;
    cmd.id = id;
    cmd.mask = mask;
    cmd.core = core;
    cmd.match_en = (state == S_MATCH);
    if (state == S_APPLY) begin
      cmd.do_add      = (req == REQ_ADD) && !full;
      cmd.do_remove   = (req == REQ_REMOVE) && any_hit;
      cmd.do_affinity = (req == REQ_AFFINITY);
      cmd.do_pin      = (req == REQ_PIN) && core_ok;
    end
  end

  genvar g;
  generate
    for (g = 0; g < TASK_DEPTH; g++) begin : g_cell
      assign occ[g] = CW'(g) < count;
      if (g == TASK_DEPTH - 1) begin : g_last
        assign up[g] = ent[g];
      end else begin : g_mid
        assign up[g] = ent[g+1];
      end
      attcs_cell u_cell (
        .clk(clk),
        .rst(rst),
        .cmd(cmd),
        .occ(occ[g]),
        .is_tail(CW'(g) == count),
        .prev_hit(hchn[g]),
        .up_entry(up[g]),
        .entry(ent[g]),
        .hit_out(hchn[g+1]),
        .first_hit(fh[g])
      );
    end
  endgenerate

  entry_t sel;
  always_comb begin
    sel = '0;
    for (int i = 0; i < TASK_DEPTH; i++) begin
      if (fh[i]) sel = sel | ent[i];
    end
  end

  logic [2:0]  pick;
  logic        pfound;
  logic [15:0] best;
  logic [15:0] lo, hi;
  always_comb begin
    pick = 3'd0;
    pfound = 1'b0;
    best = 16'd0;
    lo = loads[0];
    hi = loads[0];
    for (int j = 0; j < MAX_CORES && j < 8; j++) begin
      if (6'(j) < ncores && sel.mask[j]) begin
        if (!pfound || loads[j] < best) begin
          pfound = 1'b1;
          best = loads[j];
          pick = 3'(j);
        end
      end
    end
    for (int j = 1; j < MAX_CORES; j++) begin
      if (6'(j) < ncores) begin
        if (loads[j] < lo) lo = loads[j];
        if (loads[j] > hi) hi = loads[j];
      end
    end
  end

  logic spread;
  assign spread = (17'(hi) - 17'(lo)) > 17'(ncores / 6'(HALF_DIVISOR));

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata = {3'b0, events, r_imb, 7'(count), r_echo, r_chosen, r_status};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active_cores <= 4'd8;
      count <= '0;
      events <= '0;
      for (int j = 0; j < MAX_CORES; j++) loads[j] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) active_cores <= cfg_data;
          if (s_tvalid) begin
            req  <= s_tuser;
            id   <= s_tdata[31:0];
            mask <= s_tdata[39:32];
            core <= s_tdata[42:40];
            load <= s_tdata[58:43];
            state <= S_MATCH;
          end
        end
        S_MATCH: state <= S_APPLY;
        S_APPLY: begin
          r_status <= ST_OK;
          r_chosen <= 3'd0;
          r_echo   <= 32'd0;
          r_imb    <= 1'b0;
          unique case (req)
            REQ_ADD: begin
              if (full) r_status <= ST_FULL;
              else begin
                count <= count + 1'b1;
                r_echo <= id;
              end
            end
            REQ_REMOVE: begin
              if (!any_hit) r_status <= ST_NOTFOUND;
              else count <= count - 1'b1;
            end
            REQ_AFFINITY: if (!any_hit) r_status <= ST_NOTFOUND;
            REQ_PIN: begin
              if (!core_ok) r_status <= ST_RANGE;
              else if (!any_hit) r_status <= ST_NOTFOUND;
            end
            REQ_SELECT: begin
              if (!any_hit) r_status <= ST_NOTFOUND;
              else if (sel.pinned) r_chosen <= sel.home;
              else r_chosen <= pick;
            end
            REQ_LOAD: begin
              if (!core_ok) r_status <= ST_RANGE;
              else loads[core] <= load;
            end
            REQ_BALANCE: begin
              if (spread) begin
                events <= events + 32'd1;
                r_imb <= 1'b1;
              end
            end
            default: ;
          endcase
          state <= S_OUT;
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TASK_DEPTH)) else $error("fill count above depth");
  a_one: assert property (@(posedge clk) disable iff (rst)
    $countones({state == S_IDLE, m_tvalid}) <= 1) else $error("busy overlap");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |=> m_tvalid) else $error("result missing");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif
endmodule

// ===== tb/affinity_task_table_core_selector_tb.sv =====
module affinity_task_table_core_selector_tb;
  import attcs_pkg::*;

  localparam int DEPTH = 64;
  localparam int NCORE = 8;

  typedef struct packed {
    logic [31:0] events;
    logic        imb;
    logic [6:0]  fill;
    logic [31:0] echo;
    logic [2:0]  core;
    logic [1:0]  status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [2:0]  s_tuser = '0;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = 4'd8;

  affinity_task_table_core_selector dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // Shadow copy of the scheduler state.
  logic [31:0] tbl_id [DEPTH];
  logic [7:0]  tbl_mask [DEPTH];
  logic        tbl_pin [DEPTH];
  logic [2:0]  tbl_home [DEPTH];
  int          tbl_count = 0;
  logic [15:0] load_of [NCORE];
  logic [31:0] imb_events = 0;
  logic [3:0]  cores_reg = 4'd8;

  reply_t replies_due[$];
  int     errors = 0;
  int     send_idle = 0;
  int     recv_idle = 0;
  bit     hold_off = 1'b0;

  function automatic int cores_used();
    if (cores_reg == 0) return 1;
    if (cores_reg > NCORE) return NCORE;
    return cores_reg;
  endfunction

  function automatic int lookup(logic [31:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic reply_t schedule(logic [2:0] req, logic [31:0] id, logic [7:0] mask,
                                      logic [2:0] cidx, logic [15:0] ld);
    reply_t r;
    int n, p;
    bit hit;
    logic [15:0] best, lo, hi;
    r = '0;
    n = cores_used();
    p = lookup(id);
    case (req)
      REQ_ADD: begin
        if (tbl_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_id[tbl_count] = id;
          tbl_mask[tbl_count] = mask;
          tbl_pin[tbl_count] = 1'b0;
          tbl_home[tbl_count] = 3'd0;
          tbl_count++;
          r.echo = id;
        end
      end
      REQ_REMOVE: begin
        if (p < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          for (int j = p; j + 1 < tbl_count; j++) begin
            tbl_id[j] = tbl_id[j+1];
            tbl_mask[j] = tbl_mask[j+1];
            tbl_pin[j] = tbl_pin[j+1];
            tbl_home[j] = tbl_home[j+1];
          end
          tbl_count--;
        end
      end
      REQ_AFFINITY: begin
        if (p < 0) r.status = ST_NOTFOUND;
        else tbl_mask[p] = mask;
      end
      REQ_PIN: begin
        if (cidx >= n) begin
          r.status = ST_RANGE;
        end else if (p < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          tbl_pin[p] = 1'b1;
          tbl_home[p] = cidx;
        end
      end
      REQ_SELECT: begin
        if (p < 0) begin
          r.status = ST_NOTFOUND;
        end else if (tbl_pin[p]) begin
          r.core = tbl_home[p];
        end else begin
          hit = 1'b0;
          best = '0;
          for (int j = 0; j < n; j++)
            if (tbl_mask[p][j] && (!hit || load_of[j] < best)) begin
              hit = 1'b1;
              best = load_of[j];
              r.core = j[2:0];
            end
        end
      end
      REQ_LOAD: begin
        if (cidx >= n) r.status = ST_RANGE;
        else load_of[cidx] = ld;
      end
      REQ_BALANCE: begin
        lo = load_of[0];
        hi = load_of[0];
        for (int j = 1; j < n; j++) begin
          if (load_of[j] < lo) lo = load_of[j];
          if (load_of[j] > hi) hi = load_of[j];
        end
        if (hi - lo > n / HALF_DIVISOR) begin
          imb_events++;
          r.imb = 1'b1;
        end
      end
      default: ;
    endcase
    r.fill = tbl_count[6:0];
    r.events = imb_events;
    return r;
  endfunction

  task automatic send_request(logic [2:0] req, logic [31:0] id, logic [7:0] mask,
                              logic [2:0] cidx, logic [15:0] ld);
    @(negedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    s_tuser <= req;
    s_tdata <= {5'b00000, ld, cidx, mask, id};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    replies_due.push_back(schedule(req, id, mask, cidx, ld));
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  always @(negedge clk)
    m_tready <= !hold_off && !(recv_idle > 0 && $urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    reply_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[76:0];
      if (replies_due.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.core !== want.core) begin
          $error("chosen_core exp %0d got %0d", want.core, got.core); errors++;
        end
        if (got.echo !== want.echo) begin
          $error("echo_task_id exp %h got %h", want.echo, got.echo); errors++;
        end
        if (got.fill !== want.fill) begin
          $error("table_fill exp %0d got %0d", want.fill, got.fill); errors++;
        end
        if (got.imb !== want.imb) begin
          $error("imbalance exp %0d got %0d", want.imb, got.imb); errors++;
        end
        if (got.events !== want.events) begin
          $error("event_total exp %0d got %0d", want.events, got.events); errors++;
        end
      end
    end
  end

  task automatic drain();
    while (replies_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cores(logic [3:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cores_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_id();
    if (tbl_count > 0 && $urandom_range(9) < 8)
      return tbl_id[$urandom_range(tbl_count - 1)];
    return $urandom_range(15) == 0 ? $urandom : $urandom_range(20);
  endfunction

  task automatic test_directed();
    send_request(REQ_SELECT, 32'hFFFF_FFFF, 8'h00, 3'd0, 16'd0);
    send_request(REQ_REMOVE, 32'd5, 8'h00, 3'd0, 16'd0);
    send_request(REQ_BALANCE, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 8'hFF, 3'd7, 16'hFFFF);
    send_request(REQ_ADD, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(REQ_ADD, 32'd0, 8'hA5, 3'd0, 16'd0);
    send_request(REQ_LOAD, 32'd0, 8'h00, 3'd7, 16'hFFFF);
    send_request(REQ_LOAD, 32'd0, 8'h00, 3'd0, 16'd3);
    send_request(REQ_BALANCE, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(REQ_SELECT, 32'hFFFF_FFFF, 8'h00, 3'd0, 16'd0);
    send_request(REQ_SELECT, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(REQ_AFFINITY, 32'd0, 8'h80, 3'd0, 16'd0);
    send_request(REQ_AFFINITY, 32'd77, 8'h80, 3'd0, 16'd0);
    send_request(REQ_SELECT, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(REQ_PIN, 32'hFFFF_FFFF, 8'h00, 3'd7, 16'd0);
    send_request(REQ_SELECT, 32'hFFFF_FFFF, 8'h00, 3'd0, 16'd0);
    send_request(REQ_PIN, 32'd99, 8'h00, 3'd2, 16'd0);
    send_request(REQ_REMOVE, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(REQ_SELECT, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(3'd7, 32'h5555_AAAA, 8'h5A, 3'd5, 16'h1234);
  endtask

  task automatic test_config_edges();
    write_cores(4'd1);
    send_request(REQ_PIN, 32'd99, 8'h00, 3'd1, 16'd0);
    send_request(REQ_LOAD, 32'd0, 8'h00, 3'd1, 16'd9);
    send_request(REQ_BALANCE, 32'd0, 8'h00, 3'd0, 16'd0);
    send_request(REQ_SELECT, 32'd0, 8'h00, 3'd0, 16'd0);
    write_cores(4'd0);
    send_request(REQ_LOAD, 32'd0, 8'h00, 3'd1, 16'd9);
    send_request(REQ_PIN, 32'hFFFF_FFFF, 8'h00, 3'd0, 16'd0);
    write_cores(4'd15);
    send_request(REQ_LOAD, 32'd0, 8'h00, 3'd7, 16'd0);
    send_request(REQ_BALANCE, 32'd0, 8'h00, 3'd0, 16'd0);
    write_cores(4'd8);
  endtask

  task automatic test_full_table();
    while (tbl_count < DEPTH)
      send_request(REQ_ADD, $urandom_range(40), 8'($urandom), 3'd0, 16'd0);
    send_request(REQ_ADD, 32'd1234, 8'hFF, 3'd0, 16'd0);
    repeat (40) send_request(REQ_REMOVE, pick_id(), 8'h00, 3'd0, 16'd0);
  endtask

  task automatic test_random(int count);
    logic [2:0] req;
    for (int k = 0; k < count; k++) begin
      req = 3'($urandom_range(7));
      if (req == REQ_ADD && tbl_count > 40 && $urandom_range(1)) req = REQ_REMOVE;
      if (req == REQ_LOAD)
        send_request(req, $urandom, 8'($urandom), 3'($urandom),
                     16'($urandom_range(3) == 0 ? $urandom : $urandom_range(6)));
      else
        send_request(req, pick_id(), 8'($urandom), 3'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      test_random(30);
    join
    drain();
  endtask

  initial begin
    for (int j = 0; j < NCORE; j++) load_of[j] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_edges();
    test_full_table();
    send_idle = 24; recv_idle = 80;
    test_random(500);
    write_cores(4'd3);
    test_random(250);
    send_idle = 80; recv_idle = 24;
    write_cores(4'd5);
    test_random(400);
    send_idle = 0; recv_idle = 0;
    write_cores(4'd8);
    test_backpressure();
    test_random(650);
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
